>>> hw/rtl/console_line_editor_top_defines.svh
// Assertion macros for the console line editor top module.
`ifndef CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("console line editor: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("console line editor: next-cycle check failed");

`endif

>>> hw/rtl/cle_pkg.sv
// Types, constants and helpers shared by the console line editor modules.
package cle_pkg;

	// Size of the line store and the derived address width.
	localparam int LINE_DEPTH = 256;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int CAP_W      = 9;
	localparam int CAP_LIMIT  = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
	localparam int CAP_RESET  = 256;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [ADDR_W-1:0] addr_t;

	// Opcodes of a request.
	localparam logic [1:0] OP_KEY     = 2'd0;
	localparam logic [1:0] OP_PRELOAD = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	// Key codes.
	localparam logic [7:0] KEY_CR     = 8'h0d;
	localparam logic [7:0] KEY_LF     = 8'h0a;
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_DEL    = 8'h7f;
	localparam logic [7:0] KEY_CTRL_W = 8'h17;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_SPACE  = 8'h20;
	localparam logic [7:0] KEY_PRINT_LO = 8'h20;
	localparam logic [7:0] KEY_PRINT_HI = 8'h7f;

	// Request payload as it arrives on the input port.
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [7:0] index;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic [6:0] echo_char;
		logic [7:0] erase_count;
		logic       line_done;
		logic [7:0] line_length;
		logic [6:0] read_data;
		logic       accepted;
	} res_t;

	// Classified command kinds handed from the front to the back.
	typedef enum logic [3:0] {
		CMD_END,
		CMD_ERASE_CHAR,
		CMD_ERASE_WORD,
		CMD_ERASE_LINE,
		CMD_PRINT,
		CMD_IGNORE,
		CMD_PRELOAD,
		CMD_READ,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_code;
		logic [7:0] index;
	} cmd_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BST_IDLE,
		BST_READ,
		BST_WALK
	} back_state_t;

	// True when a line position lies inside the store.
	function automatic logic pos_in_range(logic [7:0] pos);
		return 32'(pos) < LINE_DEPTH;
	endfunction

	// Line position to store address.
	function automatic addr_t pos_to_addr(logic [7:0] pos);
		return addr_t'(pos);
	endfunction

endpackage

>>> hw/rtl/cle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/cle_front.sv
// Front end: accepts requests and classifies them into commands.
module cle_front (
	input  logic          start,
	input  logic          queue_full,
	input  cle_pkg::req_t req,
	output logic          push,
	output cle_pkg::cmd_t cmd
);
	import cle_pkg::*;

	// A request is taken whenever start is high and the queue has room.
	assign push = start && !queue_full;

	// Classify the request by opcode and key code.
	always_comb begin
		cmd.char_code = req.char_code;
		cmd.index     = req.index;
		cmd.kind      = CMD_IGNORE;
		case (req.opcode)
			OP_KEY: begin
				if (req.char_code == KEY_CR || req.char_code == KEY_LF) begin
					cmd.kind = CMD_END;
				end else if (req.char_code == KEY_BS || req.char_code == KEY_DEL) begin
					cmd.kind = CMD_ERASE_CHAR;
				end else if (req.char_code == KEY_CTRL_W) begin
					cmd.kind = CMD_ERASE_WORD;
				end else if (req.char_code == KEY_CTRL_U) begin
					cmd.kind = CMD_ERASE_LINE;
				end else if (req.char_code >= KEY_PRINT_LO && req.char_code < KEY_PRINT_HI) begin
					cmd.kind = CMD_PRINT;
				end else begin
					cmd.kind = CMD_IGNORE;
				end
			end
			OP_PRELOAD: cmd.kind = CMD_PRELOAD;
			OP_READ:    cmd.kind = CMD_READ;
			OP_CLEAR:   cmd.kind = CMD_CLEAR;
			default:    cmd.kind = CMD_IGNORE;
		endcase
	end

endmodule

>>> hw/rtl/cle_queue.sv
// Short command queue between the front end and the back end.
module cle_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cle_pkg::cmd_t        push_cmd,
	input  logic                 pop,
	output logic                 full,
	output cle_pkg::queue_head_t head
);
	import cle_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/cle_back.sv
// Back end: carries out commands against the line store and cursor.
module cle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [8:0]            cfg_data,
	input  cle_pkg::queue_head_t  head,
	output logic                  pop,
	output logic                  result_valid,
	output cle_pkg::res_t         result
);
	import cle_pkg::*;

	back_state_t      state_q, state_d;
	logic [7:0]       cursor_q, cursor_d;
	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] cap_eff;
	logic             seen_q, seen_d;
	logic             pend_q, pend_d;
	logic [7:0]       erased_q, erased_d;
	logic             rd_oor_q;
	res_t             res_q, res_d;
	logic             res_valid_q, res_valid_d;

	logic             we;
	logic [7:0]       wr_pos;
	logic [6:0]       wdata;
	logic [7:0]       rd_pos;
	logic [6:0]       ram_rdata;
	logic [6:0]       rd_char;
	logic             room;
	logic             walk_stop;
	logic             walk_last;
	logic [7:0]       cursor_dec;

	// Line store.
	cle_ram #(
		.WIDTH(7),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (we && pos_in_range(wr_pos)),
		.waddr(pos_to_addr(wr_pos)),
		.wdata(wdata),
		.raddr(pos_to_addr(rd_pos)),
		.rdata(ram_rdata)
	);

	// Effective capacity: zero acts as one, large values clamp to the limit.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (32'(cap_q) > CAP_LIMIT) begin
			cap_eff = CAP_W'(CAP_LIMIT);
		end else begin
			cap_eff = cap_q;
		end
	end

	// Shared status terms.
	assign rd_char    = rd_oor_q ? 7'd0 : ram_rdata;
	assign room       = ({1'b0, cursor_q} + CAP_W'(1)) < cap_eff;
	assign cursor_dec = cursor_q - 8'd1;
	assign walk_stop  = pend_q && seen_q && room && ({1'b0, rd_char} == KEY_SPACE);
	assign walk_last  = (cursor_dec == 8'd0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BST_IDLE: begin
				if (head.valid) begin
					if (head.cmd.kind == CMD_READ) begin
						state_d = BST_READ;
					end else if (head.cmd.kind == CMD_ERASE_WORD && cursor_q != 8'd0) begin
						state_d = BST_WALK;
					end
				end
			end
			BST_READ: state_d = BST_IDLE;
			BST_WALK: begin
				if (walk_stop || walk_last) begin
					state_d = BST_IDLE;
				end
			end
			default: state_d = BST_IDLE;
		endcase
	end

	// Datapath and outputs.
	always_comb begin
		cursor_d    = cursor_q;
		seen_d      = seen_q;
		pend_d      = pend_q;
		erased_d    = erased_q;
		res_d       = res_q;
		res_valid_d = 1'b0;
		pop         = 1'b0;
		we          = 1'b0;
		wr_pos      = cursor_q;
		wdata       = 7'd0;
		rd_pos      = cursor_dec;
		case (state_q)
			BST_IDLE: begin
				if (head.valid) begin
					pop               = 1'b1;
					res_d             = '0;
					res_d.accepted    = 1'b1;
					res_valid_d       = 1'b1;
					case (head.cmd.kind)
						CMD_END: begin
							if ({1'b0, cursor_q} >= cap_eff) begin
								cursor_d = 8'(cap_eff - CAP_W'(1));
							end
							wr_pos          = cursor_d;
							we              = 1'b1;
							res_d.echo_char = KEY_LF[6:0];
							res_d.line_done = 1'b1;
						end
						CMD_ERASE_CHAR: begin
							if (cursor_q != 8'd0) begin
								cursor_d          = cursor_dec;
								res_d.erase_count = 8'd1;
							end
						end
						CMD_ERASE_WORD: begin
							seen_d   = 1'b0;
							pend_d   = 1'b0;
							erased_d = 8'd0;
							if (cursor_q != 8'd0) begin
								res_valid_d = 1'b0;
							end
						end
						CMD_ERASE_LINE: begin
							res_d.erase_count = cursor_q;
							cursor_d          = 8'd0;
						end
						CMD_PRINT, CMD_PRELOAD: begin
							if (room) begin
								we       = 1'b1;
								wdata    = head.cmd.char_code[6:0];
								cursor_d = cursor_q + 8'd1;
								if (head.cmd.kind == CMD_PRINT) begin
									res_d.echo_char = head.cmd.char_code[6:0];
								end
							end else begin
								res_d.accepted = 1'b0;
							end
						end
						CMD_READ: begin
							rd_pos      = head.cmd.index;
							res_valid_d = 1'b0;
						end
						CMD_CLEAR: cursor_d = 8'd0;
						default: ;
					endcase
					res_d.line_length = cursor_d;
				end
			end
			BST_READ: begin
				res_d.read_data   = rd_char;
				res_d.line_length = cursor_q;
				res_valid_d       = 1'b1;
			end
			BST_WALK: begin
				// One character per cycle; the next address is read ahead.
				rd_pos = cursor_q - 8'd2;
				if (walk_stop) begin
					res_d             = '0;
					res_d.accepted    = 1'b1;
					res_d.erase_count = erased_q;
					res_d.line_length = cursor_q;
					res_valid_d       = 1'b1;
				end else begin
					seen_d   = seen_q || ({1'b0, rd_char} != KEY_SPACE);
					cursor_d = cursor_dec;
					erased_d = erased_q + 8'd1;
					pend_d   = 1'b1;
					if (walk_last) begin
						res_d             = '0;
						res_d.accepted    = 1'b1;
						res_d.erase_count = erased_d;
						res_d.line_length = cursor_d;
						res_valid_d       = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BST_IDLE;
			cursor_q    <= 8'd0;
			cap_q       <= CAP_W'(CAP_RESET);
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cursor_q    <= cursor_d;
			res_valid_q <= res_valid_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		seen_q   <= seen_d;
		pend_q   <= pend_d;
		erased_q <= erased_d;
		rd_oor_q <= !pos_in_range(rd_pos);
		res_q    <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> hw/rtl/console_line_editor_top.sv
// Console line editor: request port, capacity register and one result per request.
//
// A request is taken at a rising edge with start high and busy low; busy is high only
// while the two-entry command queue is full. Each request gives one result, shown for
// a single cycle with result_valid high; the receiver cannot hold it off. Most requests
// finish in the back end as soon as they leave the queue, a read of a stored entry also
// passes through the read state, and a word erase (Ctrl-W) walks back one character at
// a time until it stops at a word boundary or the start of the line, because it steps
// through the line store over its single read port.
// The capacity register is always ready and should be written only while idle.
module console_line_editor_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cle_pkg::req_t req,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [8:0]    cfg_data,
	output logic          result_valid,
	output cle_pkg::res_t result
);
	import cle_pkg::*;

	`include "console_line_editor_top_defines.svh"

	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	queue_head_t head;

	assign cfg_ready = 1'b1;

	cle_front u_front (
		.start     (start),
		.queue_full(busy),
		.req       (req),
		.push      (push),
		.cmd       (push_cmd)
	);

	cle_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (busy),
		.head    (head)
	);

	cle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

	// A completed line always echoes a line feed and erases nothing.
	`CLE_ASSERT_IMP(a_done_echo, result_valid && result.line_done, result.echo_char == KEY_LF[6:0] && result.erase_count == 8'd0)
	// A dropped character neither echoes nor erases.
	`CLE_ASSERT_IMP(a_drop_quiet, result_valid && !result.accepted, result.echo_char == 7'd0 && result.erase_count == 8'd0 && !result.line_done)
	// A popped command that is not a read or a word erase yields its result next cycle.
	`CLE_ASSERT_NEXT(a_pop_result, pop && head.cmd.kind != CMD_READ && head.cmd.kind != CMD_ERASE_WORD, result_valid)

endmodule
